[sv/fqsd_pkg.sv]
// Shared types, character codes and hex digit helper for the query string decoder.
package fqsd_pkg;

    localparam logic [7:0] CH_EQ    = 8'h3D;  // '='
    localparam logic [7:0] CH_AMP   = 8'h26;  // '&'
    localparam logic [7:0] CH_PCT   = 8'h25;  // '%'
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_US    = 8'h5F;  // '_'
    localparam logic [7:0] CH_X     = 8'h78;  // 'x'
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam int unsigned MAX_RES = 3;

    typedef enum logic [2:0] {
        MODE_IDLE = 3'd0,
        MODE_HEX1 = 3'd1,
        MODE_HEX2 = 3'd2,
        MODE_US   = 3'd3,
        MODE_USX  = 3'd4
    } t_mode;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex;

    // Result group of one input word: up to three bytes, sent lowest index first.
    typedef struct packed {
        logic [1:0]              cnt;
        logic [MAX_RES-1:0][7:0] bytes;
        logic                    bare;
        logic                    last;
    } t_grp;

    function automatic t_hex hex_val(input logic [7:0] c);
        t_hex h;
        h.ok  = 1'b1;
        h.val = 4'h0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.val = c[3:0];
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            h.val = c[3:0] + 4'd9;
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage

[sv/fqsd_decode.sv]
// Decode state machine: turns one input word into a group of up to three result bytes.
module fqsd_decode
    import fqsd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    output logic       o_push,
    output t_grp       o_grp
);

    t_mode      r_mode, n_mode;
    logic [7:0] r_first, n_first;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_first <= 8'h00;
        end else if (i_accept) begin
            r_mode  <= n_mode;
            r_first <= n_first;
        end
    end

    always_comb begin
        t_grp       g;
        logic [1:0] k;
        logic       idle_go;
        t_hex       hi;
        t_hex       lo;
        logic [7:0] v;

        g       = '0;
        k       = 2'd0;
        idle_go = 1'b0;
        n_mode  = r_mode;
        n_first = r_first;
        hi      = hex_val(r_first);
        lo      = hex_val(i_byte);
        if (!hi.ok) begin
            v = 8'h00;
        end else if (!lo.ok) begin
            v = {4'h0, hi.val};
        end else begin
            v = {hi.val, lo.val};
        end
        if (v == CH_CR) begin
            v = CH_LF;
        end

        unique case (r_mode)
            MODE_HEX1: begin
                n_first = i_byte;
                n_mode  = MODE_HEX2;
            end
            MODE_HEX2: begin
                g.bytes[k] = v;
                k          = k + 2'd1;
                n_mode     = MODE_IDLE;
                n_first    = 8'h00;
            end
            MODE_US: begin
                if (i_byte == CH_X) begin
                    n_mode = MODE_USX;
                end else begin
                    g.bytes[k] = CH_US;
                    k          = k + 2'd1;
                    idle_go    = 1'b1;
                end
            end
            MODE_USX: begin
                n_mode = MODE_IDLE;
                if (i_byte == CH_US) begin
                    g.bytes[k] = CH_SPACE;
                    k          = k + 2'd1;
                end else begin
                    g.bytes[k] = CH_US;
                    k          = k + 2'd1;
                    g.bytes[k] = CH_X;
                    k          = k + 2'd1;
                    idle_go    = 1'b1;
                end
            end
            default: begin
                idle_go = 1'b1;
            end
        endcase

        // Broken match and plain idle: handle the new byte from scratch.
        if (idle_go) begin
            n_mode = MODE_IDLE;
            if (i_byte == CH_EQ || i_byte == CH_AMP) begin
                g.bytes[k] = CH_SPACE;
                k          = k + 2'd1;
            end else if (i_byte == CH_PCT) begin
                n_mode = MODE_HEX1;
            end else if (i_byte == CH_US) begin
                n_mode = MODE_US;
            end else begin
                g.bytes[k] = i_byte;
                k          = k + 2'd1;
            end
        end

        // End of string: flush held underscore text, drop a partial escape.
        if (i_last) begin
            if (n_mode == MODE_US) begin
                g.bytes[k] = CH_US;
                k          = k + 2'd1;
            end else if (n_mode == MODE_USX) begin
                g.bytes[k] = CH_US;
                k          = k + 2'd1;
                g.bytes[k] = CH_X;
                k          = k + 2'd1;
            end
            n_mode  = MODE_IDLE;
            n_first = 8'h00;
            g.last  = 1'b1;
            if (k == 2'd0) begin
                g.bare = 1'b1;
                k      = 2'd1;
            end
        end

        g.cnt  = k;
        o_grp  = g;
        o_push = i_accept && (k != 2'd0);
    end

endmodule

[sv/fqsd_serializer.sv]
// Result register: holds one group and sends its bytes one word per cycle while i_ready is high.
module fqsd_serializer
    import fqsd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_grp       i_grp,
    output logic       o_ready,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_byte,
    output logic       o_has,
    output logic       o_last
);

    logic       r_valid;
    logic [1:0] r_idx;
    t_grp       r_grp;
    logic       w_final;
    logic       w_take;

    always_comb begin
        w_final = (r_idx == r_grp.cnt - 2'd1);
        w_take  = r_valid && i_ready;
        o_ready = !r_valid || (w_final && i_ready);
        o_valid = r_valid;
        o_byte  = r_grp.bytes[r_idx];
        o_has   = !r_grp.bare;
        o_last  = r_grp.last && w_final;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (i_push) begin
            r_valid <= 1'b1;
            r_idx   <= 2'd0;
        end else if (w_take) begin
            if (w_final) begin
                r_valid <= 1'b0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    // Payload: no reset.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_grp <= i_grp;
        end
    end

endmodule

[sv/form_query_string_decoder_unit.sv]
// The first result word of an input word is registered and valid in the cycle after it is accepted.
// Throughput: one input word per cycle while each yields at most one result and the output is
// not stalled; a word with more results (up to 3) holds the input until the single output
// register has sent them. A word yielding no result is taken without stall when it is free.
// Reset: i_rst_n synchronous, active low; clears decode mode, held digit and output valid.
module form_query_string_decoder_unit
    import fqsd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] in_byte
    input  logic       i_s_axis_tlast,
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] out_byte
    output logic       o_m_axis_tuser,   // [0] has_byte
    output logic       o_m_axis_tlast
);

    logic w_accept;
    logic w_push;
    t_grp w_grp;

    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;

    fqsd_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_byte   (i_s_axis_tdata),
        .i_last   (i_s_axis_tlast),
        .o_push   (w_push),
        .o_grp    (w_grp)
    );

    fqsd_serializer u_ser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_grp   (w_grp),
        .o_ready (o_s_axis_tready),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_byte  (o_m_axis_tdata),
        .o_has   (o_m_axis_tuser),
        .o_last  (o_m_axis_tlast)
    );

`ifndef NO_ASSERTIONS
    // A bare end marker only ever closes a string.
    a_bare_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser |-> o_m_axis_tlast)
        else $error("bare marker without last");

    // A bare end marker carries a zero byte.
    a_bare_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser |-> o_m_axis_tdata == 8'h00)
        else $error("bare marker with nonzero data");

    // A stalled output word blocks the input side.
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |-> !o_s_axis_tready)
        else $error("input accepted while output stalled");
`endif

endmodule
